FILE: src/key_debounce_short_long_press_core_assert.svh
// assertion macros used by the checker of the key debounce core
`ifndef KEY_DEBOUNCE_SHORT_LONG_PRESS_CORE_ASSERT_SVH
`define KEY_DEBOUNCE_SHORT_LONG_PRESS_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define KDSL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kdsl assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define KDSL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kdsl assertion failed");

`endif

FILE: src/kdsl_pkg.sv
// shared types and constants of the key debounce core
`default_nettype none

package kdsl_pkg;

    // configuration port shape
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_DEBOUNCE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_LONG     = 1'b1;

    // register reset values
    localparam logic [7:0]  DEBOUNCE_TICKS_RESET   = 8'd20;
    localparam logic [15:0] LONG_PRESS_TICKS_RESET = 16'd1000;

    // scan step, one-hot
    typedef enum logic [2:0] {
        STEP_IDLE     = 3'b001,
        STEP_DEBOUNCE = 3'b010,
        STEP_RELEASE  = 3'b100
    } step_t;

    // timing registers as seen by the scan logic
    typedef struct packed {
        logic [7:0]  debounce_ticks;
        logic [15:0] long_press_ticks;
    } cfg_t;

endpackage

`default_nettype wire

FILE: src/kdsl_in_reg.sv
// input beat register of the key debounce core
`default_nettype none

module kdsl_in_reg
#(
    parameter int KEY_COUNT = 4
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 sample_strobe,
    input  wire logic [KEY_COUNT-1:0] key_levels_n,
    input  wire logic                 beat_take,
    output logic                      beat_valid,
    output logic                      beat_strobe,
    output logic [KEY_COUNT-1:0]      beat_levels_n
);

    logic                 valid_reg;
    logic                 strobe_reg;
    logic [KEY_COUNT-1:0] levels_reg;

    // room when empty or when the held beat leaves this cycle
    assign in_ready = !valid_reg || beat_take;

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            strobe_reg <= sample_strobe;
            levels_reg <= key_levels_n;
        end
    end

    assign beat_valid    = valid_reg;
    assign beat_strobe   = strobe_reg;
    assign beat_levels_n = levels_reg;

endmodule

`default_nettype wire

FILE: src/kdsl_scan.sv
// scan state update and result register of the key debounce core
`default_nettype none

module kdsl_scan
    import kdsl_pkg::*;
#(
    parameter int KEY_COUNT = 4,
    parameter int AGE_WIDTH = 16,
    parameter int KEY_NUM_W = 2
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cfg_t                 cfg,
    input  wire logic                 beat_valid,
    input  wire logic                 beat_strobe,
    input  wire logic [KEY_COUNT-1:0] beat_levels_n,
    output logic                      beat_take,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [KEY_NUM_W-1:0]      key_number,
    output logic                      long_press
);

    localparam int CMP_W = (AGE_WIDTH > 16) ? AGE_WIDTH : 16;

    logic [KEY_COUNT-1:0] held_sample_reg, held_sample_next;
    step_t                step_reg, step_next;
    logic [KEY_COUNT-1:0] captured_reg, captured_next;
    logic [AGE_WIDTH-1:0] age_reg, age_next;
    logic [AGE_WIDTH-1:0] age_inc;
    logic [KEY_COUNT-1:0] now_set;
    logic                 single_key;
    logic                 emit;
    logic [KEY_NUM_W-1:0] key_index;
    logic                 is_long;

    logic                 out_valid_reg;
    logic [KEY_NUM_W-1:0] key_number_reg;
    logic                 long_press_reg;

    // a beat moves on when the result slot is free or being emptied
    assign beat_take = beat_valid && (!out_valid_reg || out_ready);

    // current sample and pressed set, key i is sample bit KEY_COUNT-1-i
    always_comb
    begin
        held_sample_next = beat_strobe ? beat_levels_n : held_sample_reg;
        for (int i = 0; i < KEY_COUNT; i++)
        begin
            now_set[i] = ~held_sample_next[KEY_COUNT-1-i];
        end
    end

    // saturating press age
    assign age_inc = (&age_reg) ? age_reg : age_reg + 1'b1;

    // single key set and its index
    always_comb
    begin
        single_key = (captured_reg != '0) &&
                     ((captured_reg & (captured_reg - 1'b1)) == '0);
        key_index  = '0;
        for (int i = 0; i < KEY_COUNT; i++)
        begin
            if (captured_reg[i])
            begin
                key_index = key_index | KEY_NUM_W'(i);
            end
        end
    end

    assign is_long = CMP_W'(age_inc) >= CMP_W'(cfg.long_press_ticks);

    // scan step machine
    always_comb
    begin
        step_next     = step_reg;
        captured_next = captured_reg;
        age_next      = age_reg;
        emit          = 1'b0;
        unique case (step_reg)
            STEP_IDLE:
            begin
                if (now_set != '0)
                begin
                    captured_next = now_set;
                    age_next      = '0;
                    step_next     = STEP_DEBOUNCE;
                end
            end
            STEP_DEBOUNCE:
            begin
                age_next = age_inc;
                if (CMP_W'(age_inc) >= CMP_W'(cfg.debounce_ticks))
                begin
                    step_next = (now_set == captured_reg) ? STEP_RELEASE : STEP_IDLE;
                end
            end
            STEP_RELEASE:
            begin
                age_next = age_inc;
                if (now_set != '0)
                begin
                    // a changed set voids the press
                    if (now_set != captured_reg)
                    begin
                        captured_next = '0;
                    end
                end
                else
                begin
                    emit      = single_key;
                    step_next = STEP_IDLE;
                end
            end
            default:
            begin
                step_next = STEP_IDLE;
            end
        endcase
    end

    // scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_sample_reg <= '1;
            step_reg        <= STEP_IDLE;
            captured_reg    <= '0;
            age_reg         <= '0;
        end
        else if (beat_take)
        begin
            held_sample_reg <= held_sample_next;
            step_reg        <= step_next;
            captured_reg    <= captured_next;
            age_reg         <= age_next;
        end
    end

    // result occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (beat_take && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (beat_take && emit)
        begin
            key_number_reg <= key_index;
            long_press_reg <= is_long;
        end
    end

    assign out_valid  = out_valid_reg;
    assign key_number = key_number_reg;
    assign long_press = long_press_reg;

endmodule

`default_nettype wire

FILE: src/key_debounce_short_long_press_core.sv
// Key debounce core with short / long press detection. Each input beat is one
// millisecond tick that may carry a fresh active-low key sample. A pressed key
// set must be unchanged once debounce_ticks have passed; a change while held
// voids the press. On full release of a single-key press one result beat gives
// the key number and whether the press age reached long_press_ticks; multi-key
// presses give nothing. A tick waits in the input beat register and its state
// update is written straight into the result register, so a result beat is
// registered there once its tick leaves the input beat register. One tick is
// taken every clock cycle while no result beat waits; a result beat held by a
// stalled receiver stalls the ticks behind it.
// Write the timing registers only while idle.
`default_nettype none

module key_debounce_short_long_press_core
    import kdsl_pkg::*;
#(
    parameter int KEY_COUNT = 4,
    parameter int AGE_WIDTH = 16,
    localparam int KEY_NUM_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   sample_strobe,
    input  wire logic [KEY_COUNT-1:0]   key_levels_n,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [KEY_NUM_W-1:0]        key_number,
    output logic                        long_press
);

    cfg_t                 cfg_reg;
    logic                 beat_take;
    logic                 beat_valid;
    logic                 beat_strobe;
    logic [KEY_COUNT-1:0] beat_levels_n;

    // timing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks   <= DEBOUNCE_TICKS_RESET;
            cfg_reg.long_press_ticks <= LONG_PRESS_TICKS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IDX_DEBOUNCE: cfg_reg.debounce_ticks   <= cfg_data[7:0];
                CFG_IDX_LONG:     cfg_reg.long_press_ticks <= cfg_data[15:0];
                default:          cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // input beat register
    kdsl_in_reg #(
        .KEY_COUNT(KEY_COUNT)
    ) u_in_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_strobe(sample_strobe),
        .key_levels_n (key_levels_n),
        .beat_take    (beat_take),
        .beat_valid   (beat_valid),
        .beat_strobe  (beat_strobe),
        .beat_levels_n(beat_levels_n)
    );

    // scan logic and result register
    kdsl_scan #(
        .KEY_COUNT(KEY_COUNT),
        .AGE_WIDTH(AGE_WIDTH),
        .KEY_NUM_W(KEY_NUM_W)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .beat_valid   (beat_valid),
        .beat_strobe  (beat_strobe),
        .beat_levels_n(beat_levels_n),
        .beat_take    (beat_take),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .key_number   (key_number),
        .long_press   (long_press)
    );

endmodule

`default_nettype wire

FILE: src/kdsl_checker.sv
// port-level checker of the key debounce core and its bind
`default_nettype none

`include "key_debounce_short_long_press_core_assert.svh"

module kdsl_checker
#(
    parameter int KEY_NUM_W = 2
)
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_ready,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic [KEY_NUM_W-1:0] key_number,
    input wire logic                 long_press
);

    // a result beat holds until taken
    `KDSL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // a stalled result keeps its payload
    `KDSL_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(key_number) && $stable(long_press))

    // input stalls only behind a stalled result
    `KDSL_ASSERT_IMPL(a_in_stall, !in_ready, out_valid && !out_ready)

    // a new result comes from a tick accepted at the input and held in the input beat register
    `KDSL_ASSERT_IMPL(a_out_source, $rose(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind key_debounce_short_long_press_core kdsl_checker #(
    .KEY_NUM_W(KEY_NUM_W)
) u_kdsl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .key_number(key_number),
    .long_press(long_press)
);

`default_nettype wire
